>>> src/ibmp_pkg.sv
// ----------------------------------------------------------------------------
// ibmp_pkg: shared types and constants for the ID buffer majority pick unit
// Table sizing, field widths, controller states and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ibmp_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int USED_W        = IDX_W + 1;
   localparam int ID_W          = 24;
   localparam int CNT_W         = 7;
   localparam int BYTE_W        = 8;

   localparam logic [CNT_W-1:0] COUNT_MAX = 7'd127;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_PICK,
      ST_EMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;      // capture the incoming word
      logic scan_clr;  // rewind the table scan
      logic scan_en;   // issue table reads while entries remain
      logic hit_wr;    // bump the count of the matching entry
      logic miss_ins;  // append a new entry or flag overflow
      logic pick_en;   // compare scanned entries against the best count
      logic emit;      // load the result word and clear the frame
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic pix_bg;    // held pixel is background
      logic pix_last;  // held pixel closes the frame
      logic more;      // entries left to read
      logic rd_valid;  // registered read data present
      logic hit;       // read entry matches the held ID
      logic out_free;  // result register can take a word
   } status_type;

endpackage

>>> src/ibmp_ctrl.sv
// ----------------------------------------------------------------------------
// ibmp_ctrl: sequencer for the ID buffer majority pick unit
// Steps each pixel through the table search, runs the end-of-frame pick
// scan and hands the result to the output register.
// ----------------------------------------------------------------------------
module ibmp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  ibmp_pkg::status_type status,
   output ibmp_pkg::cmd_type    cmd
);

   ibmp_pkg::state_type state_ff;
   ibmp_pkg::state_type state_in;

   // Hold the current state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ibmp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Work out the next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ibmp_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ibmp_pkg::ST_SEARCH;
            end
         end
         ibmp_pkg::ST_SEARCH: begin
            if (status.pix_bg || status.hit || (!status.rd_valid && !status.more)) begin
               state_in = status.pix_last ? ibmp_pkg::ST_PICK : ibmp_pkg::ST_IDLE;
            end
         end
         ibmp_pkg::ST_PICK: begin
            if (!status.rd_valid && !status.more) begin
               state_in = ibmp_pkg::ST_EMIT;
            end
         end
         ibmp_pkg::ST_EMIT: begin
            if (status.out_free) begin
               state_in = ibmp_pkg::ST_IDLE;
            end
         end
         default: state_in = ibmp_pkg::ST_IDLE;
      endcase
   end

   // Drive the datapath commands
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ibmp_pkg::ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.load     = req_tvalid;
            cmd.scan_clr = 1'b1;
         end
         ibmp_pkg::ST_SEARCH: begin
            if (status.pix_bg) begin
               cmd.scan_clr = 1'b1;
            end else if (status.hit) begin
               cmd.hit_wr   = 1'b1;
               cmd.scan_clr = 1'b1;
            end else if (!status.rd_valid && !status.more) begin
               cmd.miss_ins = 1'b1;
               cmd.scan_clr = 1'b1;
            end else begin
               cmd.scan_en  = 1'b1;
            end
         end
         ibmp_pkg::ST_PICK: begin
            cmd.scan_en = 1'b1;
            cmd.pick_en = 1'b1;
         end
         ibmp_pkg::ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

`ifndef ASSERT_OFF
   // Only one table update per pixel
   assert property (@(posedge clock) disable iff (reset)
      cmd.hit_wr |-> !cmd.miss_ins)
      else $error("hit and insert in the same cycle");

   // A word is only taken from the idle state and leads to a search
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ibmp_pkg::ST_SEARCH))
      else $error("accepted word did not start a search");

   // The result is only loaded from the emit state into a free register
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (status.out_free && (state_ff == ibmp_pkg::ST_EMIT)))
      else $error("result loaded while output busy");
`endif

endmodule

>>> src/ibmp_dpath.sv
// ----------------------------------------------------------------------------
// ibmp_dpath: datapath for the ID buffer majority pick unit
// Holds the ID/count table, the scan address and registered read port,
// the frame statistics and the output register.
// ----------------------------------------------------------------------------
module ibmp_dpath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [31:0]                 req_tdata,
   input  logic                        req_tlast,
   input  logic                        csr_valid,
   input  logic                        csr_data,
   input  ibmp_pkg::cmd_type           cmd,
   output ibmp_pkg::status_type        status,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [31:0]                 rsp_tdata,
   output logic [1:0]                  rsp_tuser
);

   // Configuration
   logic swap_ff;

   // Held pixel
   logic [ibmp_pkg::ID_W-1:0]   pix_id_ff;
   logic [ibmp_pkg::ID_W-1:0]   pix_id_in;
   logic                        pix_last_ff;

   // Table storage
   logic [ibmp_pkg::ID_W-1:0]   key_mem_ff [ibmp_pkg::TABLE_ENTRIES];
   logic [ibmp_pkg::CNT_W-1:0]  cnt_mem_ff [ibmp_pkg::TABLE_ENTRIES];

   // Scan and read port
   logic [ibmp_pkg::USED_W-1:0] scan_idx_ff;
   logic [ibmp_pkg::IDX_W-1:0]  rd_idx_ff;
   logic [ibmp_pkg::ID_W-1:0]   rd_key_ff;
   logic [ibmp_pkg::CNT_W-1:0]  rd_cnt_ff;
   logic                        rd_valid_ff;
   logic                        issue;

   // Frame statistics
   logic [ibmp_pkg::USED_W-1:0] used_ff;
   logic [ibmp_pkg::CNT_W-1:0]  best_ff;
   logic                        ovf_ff;
   logic [ibmp_pkg::CNT_W-1:0]  cnt_in;
   logic                        table_full;

   // Pick scan
   logic [ibmp_pkg::ID_W-1:0]   pick_ff;
   logic                        have_ff;
   logic                        pick_take;

   // Output register
   logic                        rsp_valid_ff;
   logic [ibmp_pkg::ID_W-1:0]   rsp_id_ff;
   logic [ibmp_pkg::CNT_W-1:0]  rsp_cnt_ff;
   logic                        rsp_found_ff;
   logic                        rsp_ovf_ff;

   // Hold the colour swap bit
   always_ff @(posedge clock) begin
      if (reset) begin
         swap_ff <= 1'b0;
      end else if (csr_valid) begin
         swap_ff <= csr_data;
      end
   end

   // Form the ID: red low byte, green middle, blue high; the swap bit exchanges red and blue
   always_comb begin
      if (swap_ff) begin
         pix_id_in = {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]};
      end else begin
         pix_id_in = req_tdata[23:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pix_id_ff   <= pix_id_in;
         pix_last_ff <= req_tlast;
      end
   end

   // Advance the scan address and read the table
   assign issue = cmd.scan_en && (scan_idx_ff < used_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else if (cmd.scan_clr) begin
         scan_idx_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= issue;
         if (issue) begin
            scan_idx_ff <= scan_idx_ff + ibmp_pkg::USED_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_key_ff <= key_mem_ff[scan_idx_ff[ibmp_pkg::IDX_W-1:0]];
      rd_cnt_ff <= cnt_mem_ff[scan_idx_ff[ibmp_pkg::IDX_W-1:0]];
      rd_idx_ff <= scan_idx_ff[ibmp_pkg::IDX_W-1:0];
   end

   // Saturating count bump for a hit
   assign cnt_in     = (rd_cnt_ff == ibmp_pkg::COUNT_MAX) ?
                       rd_cnt_ff : rd_cnt_ff + ibmp_pkg::CNT_W'(1);
   assign table_full = (used_ff == ibmp_pkg::USED_W'(ibmp_pkg::TABLE_ENTRIES));

   // Write the table on a hit or an insert
   always_ff @(posedge clock) begin
      if (cmd.hit_wr) begin
         cnt_mem_ff[rd_idx_ff] <= cnt_in;
      end else if (cmd.miss_ins && !table_full) begin
         key_mem_ff[used_ff[ibmp_pkg::IDX_W-1:0]] <= pix_id_ff;
         cnt_mem_ff[used_ff[ibmp_pkg::IDX_W-1:0]] <= ibmp_pkg::CNT_W'(1);
      end
   end

   // Track fill level, best count and overflow; drop them at frame end
   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         used_ff <= '0;
         best_ff <= '0;
         ovf_ff  <= 1'b0;
      end else if (cmd.hit_wr) begin
         if (cnt_in > best_ff) begin
            best_ff <= cnt_in;
         end
      end else if (cmd.miss_ins) begin
         if (table_full) begin
            ovf_ff <= 1'b1;
         end else begin
            used_ff <= used_ff + ibmp_pkg::USED_W'(1);
            if (best_ff == '0) begin
               best_ff <= ibmp_pkg::CNT_W'(1);
            end
         end
      end
   end

   // Keep the smallest ID that carries the best count
   assign pick_take = cmd.pick_en && rd_valid_ff && (rd_cnt_ff == best_ff) &&
                      (!have_ff || (rd_key_ff < pick_ff));

   always_ff @(posedge clock) begin
      if (reset || cmd.scan_clr) begin
         have_ff <= 1'b0;
      end else if (pick_take) begin
         have_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pick_take) begin
         pick_ff <= rd_key_ff;
      end
   end

   // Output register: load on emit, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_id_ff    <= have_ff ? pick_ff : '0;
         rsp_cnt_ff   <= best_ff;
         rsp_found_ff <= (best_ff != '0);
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_cnt_ff, rsp_id_ff};
   assign rsp_tuser  = {rsp_ovf_ff, rsp_found_ff};

   // Status back to the controller
   always_comb begin
      status          = '0;
      status.pix_bg   = (pix_id_ff == '0);
      status.pix_last = pix_last_ff;
      status.more     = (scan_idx_ff < used_ff);
      status.rd_valid = rd_valid_ff;
      status.hit      = rd_valid_ff && (rd_key_ff == pix_id_ff);
      status.out_free = !rsp_valid_ff || rsp_tready;
   end

`ifndef ASSERT_OFF
   // The fill level never passes the table size
   assert property (@(posedge clock) disable iff (reset)
      used_ff <= ibmp_pkg::USED_W'(ibmp_pkg::TABLE_ENTRIES))
      else $error("table fill level out of range");

   // A non-zero best count exists exactly when the table holds entries
   assert property (@(posedge clock) disable iff (reset)
      (best_ff != '0) == (used_ff != '0))
      else $error("best count and fill level disagree");

   // The scan never reads past the filled part of the table
   assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> ({1'b0, rd_idx_ff} < used_ff))
      else $error("scan read beyond filled entries");

   // Frame statistics are cleared after a result is loaded
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (used_ff == '0) && (best_ff == '0) && !ovf_ff)
      else $error("frame state not cleared after result");
`endif

endmodule

>>> src/id_buffer_majority_pick_unit.sv
// Each non-background pixel is searched against the IDs already in the table (up to 64);
// the last pixel then runs a pick scan over the table before the result word is loaded.
// Throughput: one pixel at a time, set by the single read port of the ID/count table.
// The result register lets the next frame start while a result waits to be taken.
// Reset: synchronous, active high; clears the table fill level, statistics, swap bit
// and all handshakes; table contents need no clearing.
// ----------------------------------------------------------------------------
// id_buffer_majority_pick_unit: most frequent object ID in a picking buffer
// Counts non-background pixel IDs per frame and returns the most frequent
// one (smallest on ties) on the last pixel of the frame.
// ----------------------------------------------------------------------------
module id_buffer_majority_pick_unit (
   input  logic        clock,
   input  logic        reset,
   // Pixel words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [7:0] pixel_red, [15:8] pixel_green,
                                    // [23:16] pixel_blue, [31:24] zero
   input  logic        req_tlast,   // last_pixel
   // Result words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [23:0] picked_id, [30:24] picked_count, [31] zero
   output logic [1:0]  rsp_tuser,   // [0] found, [1] overflow
   // Configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data     // swap_red_blue
);

   ibmp_pkg::cmd_type    cmd;
   ibmp_pkg::status_type status;

   // Configuration writes are always taken
   assign csr_ready = 1'b1;

   ibmp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ibmp_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
